// File: sv/ksv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_pkg: shared definitions for the plucked-string voice
// Field widths, register codes, request kinds, reset values and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ksv_pkg;

   // default geometry of the delay loop
   localparam int DELAY_DEPTH_DEF = 1024;
   localparam int FRAC_BITS_DEF   = 8;

   // stream field widths
   localparam int TYPE_W   = 2;
   localparam int SAMPLE_W = 18;
   localparam int TDATA_W  = 24;

   // loop arithmetic
   localparam int ACC_W          = 32;
   localparam int ACC_FRAC       = 8;
   localparam int COEF_W         = 17;
   localparam int COEF_FRAC      = 16;
   localparam int SCALE_W        = 16;
   localparam int SCALE_0P3      = 19661;
   localparam int TENSION_FULL   = 64;
   localparam int HELD_LPF_SHIFT = 10;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 19;
   localparam int DL_W        = 19;
   localparam int TENSION_W   = 7;

   // register reset values
   localparam logic [DL_W-1:0]      DL_RESET         = DL_W'(25600);
   localparam logic [TENSION_W-1:0] TENSION_RESET    = TENSION_W'(8);
   localparam logic [COEF_W-1:0]    HELD_DECAY_RESET = COEF_W'(64225);
   localparam logic [COEF_W-1:0]    MUTE_DECAY_RESET = COEF_W'(49152);
   localparam logic [COEF_W-1:0]    MUTE_LPF_RESET   = COEF_W'(32768);

   typedef enum logic [TYPE_W-1:0] {
      REQ_SAMPLE   = 2'd0,
      REQ_NOTE_ON  = 2'd1,
      REQ_NOTE_OFF = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DELAY_LENGTH = 3'd0,
      REG_TENSION      = 3'd1,
      REG_HELD_DECAY   = 3'd2,
      REG_MUTE_DECAY   = 3'd3,
      REG_MUTE_LPF     = 3'd4
   } csr_reg_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;      // write zero at sweep address
      logic load_req;      // capture request payload
      logic note_on;       // clear accumulator, select held set
      logic note_off;      // select mute set
      logic pos_update;    // load fast-path position
      logic div_start;     // start remainder unit
      logic pos_from_div;  // load position from remainder
      logic rd_issue;      // read tap, first product
      logic mul2;          // loop filter product
      logic wb;            // accumulator, store and result update
      logic scale_rd;      // read at sweep address
      logic scale_wr;      // write scaled entry at sweep address
   } ksv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pos_need_div;
      logic div_done;
      logic rsp_free;
      logic sweep_last;
   } ksv_status_type;

endpackage
`default_nettype wire

// File: sv/ksv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ksv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/ksv_rem_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_rem_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; gives only the remainder.
// ----------------------------------------------------------------------------
module ksv_rem_unit #(
   parameter int WIDTH = 19
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic      [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] num_ff;
   logic [WIDTH-1:0] den_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   rem_step;
   logic [WIDTH-1:0] rem_in;

   // one restoring step
   always_comb begin
      trial    = {rem_ff, num_ff[WIDTH-1]};
      rem_step = (trial >= {1'b0, den_ff}) ? (trial - {1'b0, den_ff}) : trial;
      rem_in   = rem_step[WIDTH-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(WIDTH);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[WIDTH-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: sv/ksv_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_datapath: delay loop datapath
// Configuration registers, read position, loop accumulator, delay store,
// loop filter arithmetic and the result register.
// ----------------------------------------------------------------------------
module ksv_datapath #(
   parameter int DELAY_DEPTH = ksv_pkg::DELAY_DEPTH_DEF,
   parameter int FRAC_BITS   = ksv_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ksv_pkg::ksv_cmd_type             cmd,
   output ksv_pkg::ksv_status_type               status,
   input  wire logic                             csr_valid,
   input  wire logic [ksv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ksv_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [ksv_pkg::SAMPLE_W-1:0]     req_sample,
   input  wire logic                             req_last,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_tvalid,
   output logic      [ksv_pkg::SAMPLE_W-1:0]     rsp_sample,
   output logic                                  rsp_last
);

   localparam int ADDR_W  = $clog2(DELAY_DEPTH);
   localparam int POS_W   = ADDR_W + FRAC_BITS;
   localparam int CW      = (POS_W + 1 > ksv_pkg::DL_W) ? POS_W + 1 : ksv_pkg::DL_W;
   localparam logic [CW-1:0] MAX_LEN = CW'(DELAY_DEPTH * (2 ** FRAC_BITS));
   localparam logic [CW-1:0] STEP    = CW'(2 ** FRAC_BITS);

   localparam int ACC_W    = ksv_pkg::ACC_W;
   localparam int SAMPLE_W = ksv_pkg::SAMPLE_W;
   localparam int LPF_W    = ksv_pkg::COEF_W + 1;
   localparam int PROD1_W  = ACC_W + LPF_W;
   localparam int Y_W      = PROD1_W - ksv_pkg::COEF_FRAC;
   localparam int DIFF_W   = Y_W + 1;
   localparam int PROD2_W  = DIFF_W + LPF_W;
   localparam int F_W      = PROD2_W - ksv_pkg::COEF_FRAC;
   localparam int SUM_W    = F_W + 1;
   localparam int X_W      = SAMPLE_W + ksv_pkg::ACC_FRAC;
   localparam int Q_W      = ACC_W - ksv_pkg::ACC_FRAC;
   localparam int SC_W     = ACC_W + ksv_pkg::SCALE_W;
   localparam int LB_W     = ksv_pkg::TENSION_W + 1;

   localparam logic signed [ksv_pkg::SCALE_W-1:0] SCALE_S =
      ksv_pkg::SCALE_W'(ksv_pkg::SCALE_0P3);
   localparam logic signed [LB_W-1:0] TENSION_ONE = LB_W'(ksv_pkg::TENSION_FULL);

   // configuration registers
   logic [ksv_pkg::DL_W-1:0]      dl_ff;
   logic [ksv_pkg::TENSION_W-1:0] tension_ff;
   logic [ksv_pkg::COEF_W-1:0]    held_decay_ff;
   logic [ksv_pkg::COEF_W-1:0]    mute_decay_ff;
   logic [ksv_pkg::COEF_W-1:0]    mute_lpf_ff;

   // loop state
   logic [POS_W-1:0]           pos_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       held_ff;
   logic [ADDR_W-1:0]          cnt_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       last_ff;
   logic [PROD1_W-1:0]         prod1_ff;
   logic signed [Y_W-1:0]      y_ff;
   logic [PROD2_W-1:0]         prod2_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_sample_ff;
   logic                       rsp_last_ff;

   // combinational
   logic [CW-1:0]              len;
   logic [CW-1:0]              sum;
   logic [POS_W-1:0]           pos_in;
   logic                       need_div;
   logic [CW-1:0]              rem;
   logic                       div_done;
   logic [ADDR_W-1:0]          tap;
   logic signed [LPF_W-1:0]    decay_s;
   logic signed [LB_W-1:0]     lpf_base;
   logic signed [LPF_W-1:0]    lpf_s;
   logic [ACC_W-1:0]           rd_data;
   logic signed [ACC_W-1:0]    rd_data_s;
   logic signed [PROD1_W-1:0]  prod1;
   logic signed [Y_W-1:0]      y_w;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [PROD2_W-1:0]  prod2;
   logic signed [F_W-1:0]      f_w;
   logic signed [X_W-1:0]      x_sh;
   logic signed [SUM_W-1:0]    sum_acc;
   logic [SUM_W-ACC_W:0]       sum_top;
   logic [ACC_W-1:0]           acc_new;
   logic [Q_W-1:0]             q_w;
   logic [Q_W-SAMPLE_W:0]      q_top;
   logic [SAMPLE_W-1:0]        q_sat;
   logic signed [SC_W-1:0]     sc_prod;
   logic [ACC_W-1:0]           sc_val;
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic [ACC_W-1:0]           ram_wr_data;
   logic                       ram_rd_en;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic                       rsp_free;
   logic                       sweep_last;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff         <= ksv_pkg::DL_RESET;
         tension_ff    <= ksv_pkg::TENSION_RESET;
         held_decay_ff <= ksv_pkg::HELD_DECAY_RESET;
         mute_decay_ff <= ksv_pkg::MUTE_DECAY_RESET;
         mute_lpf_ff   <= ksv_pkg::MUTE_LPF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ksv_pkg::REG_DELAY_LENGTH: dl_ff         <= csr_wdata[ksv_pkg::DL_W-1:0];
            ksv_pkg::REG_TENSION:      tension_ff    <= csr_wdata[ksv_pkg::TENSION_W-1:0];
            ksv_pkg::REG_HELD_DECAY:   held_decay_ff <= csr_wdata[ksv_pkg::COEF_W-1:0];
            ksv_pkg::REG_MUTE_DECAY:   mute_decay_ff <= csr_wdata[ksv_pkg::COEF_W-1:0];
            ksv_pkg::REG_MUTE_LPF:     mute_lpf_ff   <= csr_wdata[ksv_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // position step: clamp length, fast wrap, long wrap via remainder unit
   always_comb begin
      len = (CW'(dl_ff) > MAX_LEN) ? MAX_LEN : CW'(dl_ff);
      sum = CW'(pos_ff) + STEP;
      need_div = (len != '0) && ({1'b0, sum} >= {len, 1'b0});
      if (len == '0) begin
         pos_in = '0;
      end else if (sum < len) begin
         pos_in = sum[POS_W-1:0];
      end else begin
         pos_in = POS_W'(sum - len);
      end
   end

   ksv_rem_unit #(
      .WIDTH(CW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum),
      .divisor  (len),
      .done     (div_done),
      .remainder(rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.pos_update) begin
         pos_ff <= pos_in;
      end else if (cmd.pos_from_div) begin
         pos_ff <= rem[POS_W-1:0];
      end
   end

   assign tap = pos_ff[POS_W-1:FRAC_BITS];

   // coefficient select
   always_comb begin
      lpf_base = TENSION_ONE - signed'({1'b0, tension_ff});
      if (held_ff) begin
         decay_s = {1'b0, held_decay_ff};
         lpf_s   = LPF_W'({lpf_base, {ksv_pkg::HELD_LPF_SHIFT{1'b0}}});
      end else begin
         decay_s = {1'b0, mute_decay_ff};
         lpf_s   = {1'b0, mute_lpf_ff};
      end
   end

   // loop arithmetic: decay product, filter product, sum and saturation
   always_comb begin
      rd_data_s = rd_data;
      prod1     = PROD1_W'(acc_ff) * PROD1_W'(decay_s);
      y_w       = prod1_ff[ksv_pkg::COEF_FRAC +: Y_W];
      diff      = DIFF_W'(rd_data_s) - DIFF_W'(y_w);
      prod2     = PROD2_W'(diff) * PROD2_W'(lpf_s);
      f_w       = prod2_ff[ksv_pkg::COEF_FRAC +: F_W];
      x_sh      = {x_ff, {ksv_pkg::ACC_FRAC{1'b0}}};
      sum_acc   = SUM_W'(y_ff) + SUM_W'(f_w) + SUM_W'(x_sh);
      sum_top   = sum_acc[SUM_W-1:ACC_W-1];
      if ((&sum_top) || !(|sum_top)) begin
         acc_new = sum_acc[ACC_W-1:0];
      end else if (sum_acc[SUM_W-1]) begin
         acc_new = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_new = {1'b0, {(ACC_W-1){1'b1}}};
      end
      // output sample: divide by 2^ACC_FRAC toward zero, then saturate
      q_w = acc_new[ACC_W-1:ksv_pkg::ACC_FRAC]
          + Q_W'(acc_new[ACC_W-1] && (|acc_new[ksv_pkg::ACC_FRAC-1:0]));
      q_top = q_w[Q_W-1:SAMPLE_W-1];
      if ((&q_top) || !(|q_top)) begin
         q_sat = q_w[SAMPLE_W-1:0];
      end else if (q_w[Q_W-1]) begin
         q_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         q_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      // note-on scaling of one store entry
      sc_prod = SC_W'(rd_data_s) * SC_W'(SCALE_S);
      sc_val  = sc_prod[ksv_pkg::COEF_FRAC +: ACC_W];
   end

   // product registers
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         prod1_ff <= prod1;
      end
      if (cmd.mul2) begin
         y_ff     <= y_w;
         prod2_ff <= prod2;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         x_ff    <= req_sample;
         last_ff <= req_last;
      end
   end

   // accumulator and note state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= 1'b0;
      end else if (cmd.note_on) begin
         acc_ff  <= '0;
         held_ff <= 1'b1;
      end else if (cmd.note_off) begin
         held_ff <= 1'b0;
      end else if (cmd.wb) begin
         acc_ff <= acc_new;
      end
   end

   // sweep address for clearing pass and note-on scaling
   assign sweep_last = (cnt_ff == ADDR_W'(DELAY_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.clear_wr || cmd.scale_wr) begin
         cnt_ff <= sweep_last ? '0 : cnt_ff + ADDR_W'(1);
      end
   end

   // delay store ports
   always_comb begin
      ram_rd_en   = cmd.rd_issue || cmd.scale_rd;
      ram_rd_addr = cmd.scale_rd ? cnt_ff : tap;
      ram_wr_en   = cmd.clear_wr || cmd.scale_wr || cmd.wb;
      ram_wr_addr = cmd.wb ? tap : cnt_ff;
      if (cmd.clear_wr) begin
         ram_wr_data = '0;
      end else if (cmd.scale_wr) begin
         ram_wr_data = sc_val;
      end else begin
         ram_wr_data = acc_new;
      end
   end

   ksv_ram #(
      .WIDTH(ACC_W),
      .DEPTH(DELAY_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(rd_data)
   );

   // result register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.wb) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         rsp_sample_ff <= q_sat;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      status.pos_need_div = need_div;
      status.div_done     = div_done;
      status.rsp_free     = rsp_free;
      status.sweep_last   = sweep_last;
   end

endmodule
`default_nettype wire

// File: sv/ksv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksv_ctrl: sequencer for the plucked-string voice
// Runs the clearing and note-on sweeps, decodes requests and steps the
// datapath through position update, tap read, two products and write back.
// ----------------------------------------------------------------------------
module ksv_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic [ksv_pkg::TYPE_W-1:0]  req_tuser,
   output logic                             req_tready,
   input  wire ksv_pkg::ksv_status_type     status,
   output ksv_pkg::ksv_cmd_type             cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_POS   = 9'b000000100,
      ST_DIV   = 9'b000001000,
      ST_RD    = 9'b000010000,
      ST_MUL   = 9'b000100000,
      ST_WB    = 9'b001000000,
      ST_SC_RD = 9'b010000000,
      ST_SC_WR = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               unique case (req_tuser)
                  ksv_pkg::REQ_SAMPLE: begin
                     state_in = ST_POS;
                  end
                  ksv_pkg::REQ_NOTE_ON: begin
                     cmd.note_on = 1'b1;
                     state_in    = ST_SC_RD;
                  end
                  ksv_pkg::REQ_NOTE_OFF: begin
                     cmd.note_off = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_POS: begin
            if (status.pos_need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.pos_update = 1'b1;
               state_in       = ST_RD;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.pos_from_div = 1'b1;
               state_in         = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul2 = 1'b1;
            state_in = ST_WB;
         end
         ST_WB: begin
            if (status.rsp_free) begin
               cmd.wb   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SC_RD: begin
            cmd.scale_rd = 1'b1;
            state_in     = ST_SC_WR;
         end
         ST_SC_WR: begin
            cmd.scale_wr = 1'b1;
            state_in     = status.sweep_last ? ST_IDLE : ST_SC_RD;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/karplus_strong_string_voice.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// karplus_strong_string_voice: plucked-string voice, one sample per sample request
// Controller plus datapath around a circular delay store.
// ----------------------------------------------------------------------------
// After reset the block clears all DELAY_DEPTH entries of its delay store
// (1024 by default), one entry per cycle, before it takes its first request;
// configuration writes are taken throughout. A sample request runs from
// transfer to result through the position update, the tap read from the store
// together with the decay product, the loop filter product and the write back,
// each in a state of its own; the write back waits while a result is pending.
// When the position overshoots the delay length by at least one length (after
// the length register was lowered, or while the length is under one step) a
// bit-serial remainder unit works out the new position. A note-on scales every
// store entry, reading it and then writing it back; a note-off needs no sweep.
// A finished result waits in an output register while the next request runs.
// ----------------------------------------------------------------------------
module karplus_strong_string_voice #(
   parameter int DELAY_DEPTH = ksv_pkg::DELAY_DEPTH_DEF,
   parameter int FRAC_BITS   = ksv_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ksv_pkg::TDATA_W-1:0]     req_tdata,  // [17:0] sample_in
   input  wire logic [ksv_pkg::TYPE_W-1:0]      req_tuser,  // [1:0] req_type
   input  wire logic                            req_tlast,  // block_end
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [ksv_pkg::TDATA_W-1:0]     rsp_tdata,  // [17:0] sample_out
   output logic                                 rsp_tlast,  // last_out
   // register write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ksv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ksv_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ksv_pkg::ksv_cmd_type    cmd;
   ksv_pkg::ksv_status_type status;
   logic [ksv_pkg::SAMPLE_W-1:0] rsp_sample;

   // register writes complete in the cycle they are offered
   assign csr_ready = 1'b1;

   ksv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tuser (req_tuser),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ksv_datapath #(
      .DELAY_DEPTH(DELAY_DEPTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_sample(req_tdata[ksv_pkg::SAMPLE_W-1:0]),
      .req_last  (req_tlast),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_sample(rsp_sample),
      .rsp_last  (rsp_tlast)
   );

   // pad result field to whole bytes
   assign rsp_tdata = {{(ksv_pkg::TDATA_W - ksv_pkg::SAMPLE_W){1'b0}}, rsp_sample};

   // a result is never written over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> status.rsp_free)
      else $error("result register written while a result is pending");

   // position is taken from the remainder unit only once it has finished
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      cmd.pos_from_div |-> status.div_done)
      else $error("position loaded before remainder was ready");

   // no request is taken right after reset: clearing pass runs first
   a_clear_first: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("request taken during clearing pass");

endmodule
`default_nettype wire

// File: tb/karplus_strong_string_voice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// karplus_strong_string_voice_checker: result predictor and scoreboard
// Watches the request, result and register channels of the plucked-string
// voice. It keeps its own copy of the delay loop and registers, works out the
// output sample for every accepted sample request and compares each result
// transfer, field by field, with the oldest sample still owed.
// ----------------------------------------------------------------------------
module karplus_strong_string_voice_checker #(
   parameter int DELAY_DEPTH = ksv_pkg::DELAY_DEPTH_DEF,
   parameter int FRAC_BITS   = ksv_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ksv_pkg::TDATA_W-1:0]     req_tdata,  // [17:0] sample_in
   input  logic [ksv_pkg::TYPE_W-1:0]      req_tuser,  // [1:0] req_type
   input  logic                            req_tlast,  // block_end
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ksv_pkg::TDATA_W-1:0]     rsp_tdata,  // [17:0] sample_out
   input  logic                            rsp_tlast,  // last_out
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [ksv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ksv_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              samples_pending
);
   import ksv_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] level;
      logic                       last;
   } voice_sample_t;

   voice_sample_t owed_samples[$];
   voice_sample_t oldest;

   // register copies
   logic [DL_W-1:0]      loop_length;
   logic [TENSION_W-1:0] tension;
   logic [COEF_W-1:0]    held_decay;
   logic [COEF_W-1:0]    mute_decay;
   logic [COEF_W-1:0]    mute_lpf;

   // loop state
   logic signed [ACC_W-1:0] delay_line [DELAY_DEPTH];
   longint unsigned         tap_position;
   logic signed [ACC_W-1:0] string_level;
   bit                      note_held;

   // Q16 product back to loop scale, rounding toward minus infinity
   function automatic longint floor_q16(input longint v);
      return v >>> COEF_FRAC;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // note-on: loop level cleared, whole line scaled down by 0.3
   task automatic pluck_string();
      for (int i = 0; i < DELAY_DEPTH; i++) begin
         delay_line[i] = ACC_W'(floor_q16(longint'(delay_line[i]) * SCALE_0P3));
      end
      string_level = '0;
      note_held    = 1'b1;
   endtask

   // one sample step: advance tap, decay, loop filter, write back
   task automatic advance_string(input logic [SAMPLE_W-1:0] excitation, input logic last);
      longint unsigned span;
      longint unsigned span_max;
      int unsigned     tap;
      longint          x;
      longint          y;
      longint          decay;
      longint          lpf;
      longint          level;

      span     = loop_length;
      span_max = longint'(DELAY_DEPTH) << FRAC_BITS;
      if (span > span_max) span = span_max;
      if (span == 0) begin
         tap_position = 0;
      end else begin
         tap_position += 64'd1 << FRAC_BITS;
         if (tap_position >= span) tap_position = tap_position % span;
      end
      tap = int'(tap_position >> FRAC_BITS);
      if (tap >= DELAY_DEPTH) tap = DELAY_DEPTH - 1;

      x = $signed(excitation);
      if (note_held) begin
         decay = held_decay;
         lpf   = (longint'(TENSION_FULL) - longint'(tension)) * (longint'(1) << HELD_LPF_SHIFT);
      end else begin
         decay = mute_decay;
         lpf   = mute_lpf;
      end

      y = floor_q16(longint'(string_level) * decay);
      y = y + floor_q16((longint'(delay_line[tap]) - y) * lpf) + x * (longint'(1) << ACC_FRAC);
      level = clamp(y, -(longint'(1) << (ACC_W - 1)), (longint'(1) << (ACC_W - 1)) - 1);
      string_level   = level[ACC_W-1:0];
      delay_line[tap] = string_level;

      // output: truncate toward zero, then saturate to the sample range
      level = level / (longint'(1) << ACC_FRAC);
      level = clamp(level, -(longint'(1) << (SAMPLE_W - 1)),
                    (longint'(1) << (SAMPLE_W - 1)) - 1);
      owed_samples.push_back('{level: level[SAMPLE_W-1:0], last: last});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loop_length  = DL_RESET;
         tension      = TENSION_RESET;
         held_decay   = HELD_DECAY_RESET;
         mute_decay   = MUTE_DECAY_RESET;
         mute_lpf     = MUTE_LPF_RESET;
         for (int i = 0; i < DELAY_DEPTH; i++) delay_line[i] = '0;
         tap_position = 0;
         string_level = '0;
         note_held    = 1'b0;
         owed_samples.delete();
         mismatch_count = 0;
      end else begin
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DELAY_LENGTH: loop_length = csr_wdata[DL_W-1:0];
               REG_TENSION:      tension     = csr_wdata[TENSION_W-1:0];
               REG_HELD_DECAY:   held_decay  = csr_wdata[COEF_W-1:0];
               REG_MUTE_DECAY:   mute_decay  = csr_wdata[COEF_W-1:0];
               REG_MUTE_LPF:     mute_lpf    = csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end

         // result transfer: checked before this edge's request is predicted
         if (rsp_tvalid && rsp_tready) begin
            if (owed_samples.size() == 0) begin
               $error("result with no sample owed: sample_out %0d, last_out %0b",
                      $signed(rsp_tdata[SAMPLE_W-1:0]), rsp_tlast);
               mismatch_count++;
            end else begin
               oldest = owed_samples.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== oldest.level) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         oldest.level, $signed(rsp_tdata[SAMPLE_W-1:0]));
                  mismatch_count++;
               end
               if (rsp_tlast !== oldest.last) begin
                  $error("last_out mismatch: expected %0b, actual %0b", oldest.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end

         // request transfer; the undefined kind is ignored
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               REQ_SAMPLE:   advance_string(req_tdata[SAMPLE_W-1:0], req_tlast);
               REQ_NOTE_ON:  pluck_string();
               REQ_NOTE_OFF: note_held = 1'b0;
               default: ;
            endcase
         end
      end
      samples_pending = owed_samples.size();
   end

endmodule

// File: tb/karplus_strong_string_voice_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// karplus_strong_string_voice_test: top of the plucked-string voice bench
// Drives requests and register writes, throttles the result side and gives
// the verdict. A directed opening hits field extremes and every request kind
// and is followed by one long result stall; then register phases at their
// extremes and at random run plucked phrases mixed with noise under three idling patterns.
// ----------------------------------------------------------------------------
module karplus_strong_string_voice_test;
   import ksv_pkg::*;

   localparam int     DEPTH         = DELAY_DEPTH_DEF;
   localparam int     FRAC          = FRAC_BITS_DEF;
   localparam int     PHASE_COUNT   = 9;
   localparam int     PHASE_ITEMS   = 70;
   localparam int     SETTLE_CYCLES = 2 * DEPTH + 64;
   localparam longint CYCLE_LIMIT   = 1_500_000;

   // codes the block leaves unmapped
   localparam logic [TYPE_W-1:0]      REQ_UNDEFINED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED  = 3'd7;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata  = '0;
   logic [TYPE_W-1:0]      req_tuser  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_W-1:0]     rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int     mismatch_count;
   int     samples_pending;
   int     send_gap_pct    = 0;
   int     recv_stall_pct  = 0;
   int     hold_off_cycles = 0;
   int     items_sent      = 0;
   longint cycle_count     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   karplus_strong_string_voice u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   karplus_strong_string_voice_checker #(
      .DELAY_DEPTH (DEPTH),
      .FRAC_BITS   (FRAC)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .samples_pending (samples_pending)
   );

   // result side: random stalls, or a counted hold-off when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("karplus_strong_string_voice_test: FAIL");
         $finish;
      end
   end

   // one request transfer; ends at the falling edge after acceptance
   task automatic offer_request(input logic [TYPE_W-1:0] kind,
                                input logic [SAMPLE_W-1:0] excitation, input logic last);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= TDATA_W'(excitation);
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind != REQ_UNDEFINED) items_sent++;
      @(negedge clock);
   endtask

   task automatic csr_transfer(input logic [CSR_INDEX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // all registers back to back, plus a write to an unmapped index
   task automatic write_registers(input logic [CSR_DATA_W-1:0] length_q8,
                                  input logic [CSR_DATA_W-1:0] tension_val,
                                  input logic [CSR_DATA_W-1:0] held_decay_q16,
                                  input logic [CSR_DATA_W-1:0] mute_decay_q16,
                                  input logic [CSR_DATA_W-1:0] mute_lpf_q16);
      csr_transfer(REG_DELAY_LENGTH, length_q8);
      csr_transfer(REG_TENSION, tension_val);
      csr_transfer(REG_HELD_DECAY, held_decay_q16);
      csr_transfer(REG_MUTE_DECAY, mute_decay_q16);
      csr_transfer(REG_MUTE_LPF, mute_lpf_q16);
      csr_transfer(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // drain results, then let a trailing note-on sweep finish
   task automatic settle_voice();
      req_tvalid <= 1'b0;
      wait (samples_pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_excitation();
      case ($urandom_range(0, 4))
         0: return SAMPLE_W'($urandom);
         1: return SAMPLE_W'($urandom_range(0, 1023) - 512);
         2: return SAMPLE_W'(18'h1FFFF);
         3: return SAMPLE_W'(18'h20000);
         default: return '0;
      endcase
   endfunction

   function automatic logic coin_last();
      return ($urandom_range(0, 7) == 0);
   endfunction

   // pluck, excite, let it ring, release, tail
   task automatic play_phrase();
      int burst;
      int ring;
      int tail;
      burst = $urandom_range(2, 16);
      ring  = $urandom_range(10, 60);
      tail  = $urandom_range(4, 24);
      offer_request(REQ_NOTE_ON, SAMPLE_W'($urandom), coin_last());
      repeat (burst) offer_request(REQ_SAMPLE, pick_excitation(), coin_last());
      repeat (ring) offer_request(REQ_SAMPLE, SAMPLE_W'($urandom_range(0, 15) - 8), coin_last());
      offer_request(REQ_NOTE_OFF, SAMPLE_W'($urandom), coin_last());
      repeat (tail) offer_request(REQ_SAMPLE, pick_excitation(), coin_last());
   endtask

   // unordered kinds: stray note-offs, repeated note-ons, undefined kinds
   task automatic noise_burst();
      int pick;
      repeat ($urandom_range(4, 12)) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            offer_request(REQ_NOTE_ON, SAMPLE_W'($urandom), coin_last());
         else if (pick <= 2)
            offer_request(REQ_NOTE_OFF, SAMPLE_W'($urandom), coin_last());
         else if (pick <= 4)
            offer_request(REQ_UNDEFINED, SAMPLE_W'($urandom), coin_last());
         else
            offer_request(REQ_SAMPLE, pick_excitation(), coin_last());
      end
   endtask

   task automatic run_random_phase(input int budget);
      int start;
      start = items_sent;
      while (items_sent - start < budget) begin
         if ($urandom_range(0, 99) < 80) play_phrase();
         else noise_burst();
      end
   endtask

   // register settings per phase: extremes first, then random
   task automatic configure_phase(input int phase);
      case (phase)
         0: write_registers(256, 0, 65536, 0, 65536);
         1: write_registers(0, 64, 0, 65536, 0);
         2: write_registers(19'h7FFFF, 127, 131071, 131071, 131071);
         3: write_registers(262144, 8, 64225, 49152, 32768);
         // shorter than the position reached in the previous phase
         4: write_registers(1000, 20, 60000, 50000, 40000);
         5, 7: write_registers(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                               CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                               CSR_DATA_W'($urandom));
         default: write_registers($urandom_range(256, 8000), $urandom_range(0, 64),
                                  $urandom_range(40000, 65536),
                                  $urandom_range(20000, 65536),
                                  $urandom_range(10000, 65536));
      endcase
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct   = 11;
      recv_stall_pct = 64;

      // directed opening, reset register values
      offer_request(REQ_SAMPLE, 18'h1FFFF, 1'b0);
      offer_request(REQ_SAMPLE, 18'h20000, 1'b1);
      offer_request(REQ_SAMPLE, 18'h00000, 1'b0);
      offer_request(REQ_UNDEFINED, 18'h3FFFF, 1'b1);
      offer_request(REQ_NOTE_OFF, 18'h00000, 1'b0);
      offer_request(REQ_NOTE_ON, 18'h00000, 1'b0);
      // drive the output into saturation both ways
      repeat (6) offer_request(REQ_SAMPLE, 18'h1FFFF, 1'b0);
      repeat (4) offer_request(REQ_SAMPLE, 18'h20000, 1'b0);
      // re-pluck with a loaded line, then small levels near zero
      offer_request(REQ_NOTE_ON, 18'h3FFFF, 1'b1);
      offer_request(REQ_SAMPLE, 18'h00000, 1'b0);
      offer_request(REQ_SAMPLE, 18'h00001, 1'b0);
      offer_request(REQ_SAMPLE, 18'h3FFFF, 1'b1);
      offer_request(REQ_NOTE_OFF, 18'h00000, 1'b0);
      offer_request(REQ_SAMPLE, 18'h2AAAA, 1'b0);
      offer_request(REQ_SAMPLE, 18'h15555, 1'b1);

      // long result stall while requests keep coming
      hold_off_cycles = 400;
      send_gap_pct    = 0;
      repeat (24) offer_request(REQ_SAMPLE, pick_excitation(), coin_last());
      send_gap_pct = 11;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == PHASE_COUNT / 3) begin
            send_gap_pct   = 64;
            recv_stall_pct = 11;
         end else if (phase == 2 * PHASE_COUNT / 3) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         settle_voice();
         configure_phase(phase);
         run_random_phase(PHASE_ITEMS);
      end

      req_tvalid <= 1'b0;
      wait (samples_pending == 0);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && samples_pending == 0) begin
         $display("karplus_strong_string_voice_test: PASS");
      end else begin
         $display("karplus_strong_string_voice_test: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/ksv_pkg.sv
sv/ksv_ram.sv
sv/ksv_rem_unit.sv
sv/ksv_datapath.sv
sv/ksv_ctrl.sv
sv/karplus_strong_string_voice.sv
tb/karplus_strong_string_voice_checker.sv
tb/karplus_strong_string_voice_test.sv
